>>> rtl/cda_pkg.sv
`timescale 1ns / 1ps

package cda_pkg;

  localparam int BUCKETS     = 6;
  localparam int WEIGHT_BITS = 8;

  localparam int LANES   = 6;
  localparam int FIELD_W = 8;
  localparam int WUSE    = (WEIGHT_BITS < FIELD_W) ? WEIGHT_BITS : FIELD_W;
  localparam int CNT_W   = 5;
  localparam int DEN_W   = CNT_W + 1;
  localparam int PROD_W  = WUSE + DEN_W;
  localparam int SCORE_W = 6;
  localparam int SPREAD_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [SPREAD_W-1:0] SPREAD_RST = 8'd24;
  localparam logic [CNT_W-1:0]    CAP_RST    = 5'd7;
  localparam logic [CNT_W-1:0]    BASE_RST   = 5'd8;

  typedef logic [WUSE-1:0]    weight_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [DEN_W-1:0]   den_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [SCORE_W-1:0] score_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPREAD = 2'd0,
    REG_CAP    = 2'd1,
    REG_BASE   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [FIELD_W-1:0] weight_0;
    logic [FIELD_W-1:0] weight_1;
    logic [FIELD_W-1:0] weight_2;
    logic [FIELD_W-1:0] weight_3;
    logic [FIELD_W-1:0] weight_4;
    logic [FIELD_W-1:0] weight_5;
  } in_beat_t;

  typedef struct packed {
    score_t score_0;
    score_t score_1;
    score_t score_2;
    score_t score_3;
    score_t score_4;
    score_t score_5;
    logic   short_total;
  } out_beat_t;

  typedef struct packed {
    logic               any;
    logic [BUCKETS-1:0] win;
  } pick_t;

endpackage

>>> rtl/cda_lane.sv
`timescale 1ns / 1ps

module cda_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [cda_pkg::FIELD_W-1:0]           weight_i,
  input  logic                                  award_i,
  input  cda_pkg::cnt_t                         cap_i,
  input  cda_pkg::den_t [cda_pkg::BUCKETS-1:0]  den_i,
  output cda_pkg::cnt_t                         held_o,
  output cda_pkg::den_t                         den_o,
  output logic                                  elig_o,
  output cda_pkg::prod_t [cda_pkg::BUCKETS-1:0] prod_o
);
  import cda_pkg::*;

  weight_t w_q;
  cnt_t    held_q, held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (load_i) begin
      w_q <= weight_i[WUSE-1:0];
    end
  end

  always_comb begin
    held_d = held_q;
    if (load_i) begin
      held_d = '0;
    end else if (award_i) begin
      held_d = held_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  assign held_o = held_q;
  assign den_o  = {1'b0, held_q} + den_t'(1);
  assign elig_o = (held_q < cap_i);

  // own weight against every lane's divisor
  always_comb begin
    for (int j = 0; j < BUCKETS; j++) begin
      prod_o[j] = prod_t'(w_q) * prod_t'(den_i[j]);
    end
  end

endmodule

>>> rtl/cda_merge.sv
`timescale 1ns / 1ps

module cda_merge (
  input  logic [cda_pkg::BUCKETS-1:0]                         elig_i,
  input  cda_pkg::prod_t [cda_pkg::BUCKETS-1:0][cda_pkg::BUCKETS-1:0] prod_i,
  output cda_pkg::pick_t                                      pick_o
);
  import cda_pkg::*;

  logic [BUCKETS-1:0] win;

  // lane i wins if it strictly beats every lower eligible lane
  // and is not beaten by any higher eligible lane
  always_comb begin
    for (int i = 0; i < BUCKETS; i++) begin
      win[i] = elig_i[i];
      for (int j = 0; j < BUCKETS; j++) begin
        if (j < i) begin
          if (elig_i[j] && !(prod_i[i][j] > prod_i[j][i])) begin
            win[i] = 1'b0;
          end
        end else if (j > i) begin
          if (elig_i[j] && (prod_i[j][i] > prod_i[i][j])) begin
            win[i] = 1'b0;
          end
        end
      end
    end
  end

  assign pick_o.win = win;
  assign pick_o.any = |elig_i;

endmodule

>>> rtl/capped_divisor_apportion.sv
`timescale 1ns / 1ps
// result: registered when the award loop has given spread_points or no lane is eligible
// the loop ends early when every bucket reaches its cap (one point per cycle)
// input stalls while an item is in the six-lane award loop or its result waits for a free output
// the next item is taken while the previous result still waits at the output
// reset: asynchronous active low, registers return to 24 / 7 / 8, no result pending
module capped_divisor_apportion (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cda_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cda_pkg::out_beat_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cda_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cda_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cda_pkg::*;

  state_e state_q, state_d;

  logic [SPREAD_W-1:0] spread_q;
  cnt_t                cap_q;
  cnt_t                base_q;
  logic [SPREAD_W-1:0] given_q, given_d;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  logic load, award_en, finish, done, out_free;

  logic [FIELD_W-1:0] wt [LANES];
  cnt_t  [BUCKETS-1:0]              held;
  den_t  [BUCKETS-1:0]              den;
  logic  [BUCKETS-1:0]              elig;
  prod_t [BUCKETS-1:0][BUCKETS-1:0] prod;
  pick_t                            pick;
  score_t                           score [LANES];

  assign wt[0] = in_data_i.weight_0;
  assign wt[1] = in_data_i.weight_1;
  assign wt[2] = in_data_i.weight_2;
  assign wt[3] = in_data_i.weight_3;
  assign wt[4] = in_data_i.weight_4;
  assign wt[5] = in_data_i.weight_5;

  for (genvar i = 0; i < BUCKETS; i++) begin : g_lane
    cda_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (load),
      .weight_i (wt[i]),
      .award_i  (award_en & pick.win[i]),
      .cap_i    (cap_q),
      .den_i    (den),
      .held_o   (held[i]),
      .den_o    (den[i]),
      .elig_o   (elig[i]),
      .prod_o   (prod[i])
    );
  end

  cda_merge u_merge (
    .elig_i (elig),
    .prod_i (prod),
    .pick_o (pick)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_score
    if (i < BUCKETS) begin : g_used
      assign score[i] = score_t'(base_q) + score_t'(held[i]);
    end else begin : g_unused
      assign score[i] = '0;
    end
  end

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q <= SPREAD_RST;
      cap_q    <= CAP_RST;
      base_q   <= BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SPREAD: spread_q <= cfg_data_i[SPREAD_W-1:0];
        REG_CAP:    cap_q    <= cfg_data_i[CNT_W-1:0];
        REG_BASE:   base_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = (given_q == spread_q) || !pick.any;

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    load       = 1'b0;
    award_en   = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        load = in_valid_i;
      end
      ST_RUN: begin
        award_en = !done;
        finish   = done && out_free;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    given_d = given_q;
    if (load) begin
      given_d = '0;
    end else if (award_en) begin
      given_d = given_q + SPREAD_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (finish) begin
      out_valid_d       = 1'b1;
      out_d.score_0     = score[0];
      out_d.score_1     = score[1];
      out_d.score_2     = score[2];
      out_d.score_3     = score[3];
      out_d.score_4     = score[4];
      out_d.score_5     = score[5];
      out_d.short_total = (given_q != spread_q);
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      given_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      given_q     <= given_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // at most one lane takes a point
  a_win_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pick.win))
    else $error("more than one lane selected");

  // an eligible lane always yields a winner
  a_any_has_win : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick.any |-> $onehot(pick.win))
    else $error("eligible lanes but no winner");

  // a new result only comes out of the award loop
  a_out_from_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RUN))
    else $error("result beat without a finished item");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cda_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int NO_PICK = -1;
  localparam int DIR_N   = 39;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    in_beat_t               beat;
    logic                   typed;
    out_beat_t              want;
  } row_t;

  // directed rows, typed results only where obvious
  localparam row_t DIR_TAB [DIR_N] = '{
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h0000_0000_0000, 1'b1,
      {6'd15, 6'd15, 6'd15, 6'd11, 6'd8, 6'd8, 1'b0}},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'hFFFF_FFFF_FFFF, 1'b1, {{6{6'd12}}, 1'b0}},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h0000_0000_00FF, 1'b1,
      {6'd15, 6'd15, 6'd11, 6'd8, 6'd8, 6'd15, 1'b0}},
    '{ROW_CFG,  REG_CAP,    8'd0,   48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h0102_0304_0506, 1'b1, {{6{6'd8}}, 1'b1}},
    '{ROW_CFG,  REG_SPREAD, 8'd0,   48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'hFFFF_FFFF_FFFF, 1'b1, {{6{6'd8}}, 1'b0}},
    '{ROW_CFG,  REG_SPREAD, 8'd255, 48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_CAP,    8'd31,  48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE,   8'd31,  48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h8040_2010_0804, 1'b1, {{6{6'd62}}, 1'b1}},
    '{ROW_CFG,  REG_SPREAD, 8'd180, 48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_CAP,    8'd30,  48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE,   8'd30,  48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'hFF00_FF00_FF00, 1'b1, {{6{6'd60}}, 1'b0}},
    '{ROW_CFG,  REG_SPREAD, 8'd181, 48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'hFF00_FF00_FF00, 1'b1, {{6{6'd60}}, 1'b1}},
    '{ROW_CFG,  REG_SPREAD, 8'd0,   48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_CAP,    8'd0,   48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE,   8'd0,   48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h0000_0000_0000, 1'b1, {{6{6'd0}}, 1'b0}},
    '{ROW_CFG,  REG_NONE,   8'hFF,  48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h0000_0000_0000, 1'b1, {{6{6'd0}}, 1'b0}},
    '{ROW_CFG,  REG_CAP,    8'hFF,  48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE,   8'hE5,  48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_SPREAD, 8'd24,  48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h6432_1E14_0A05, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'hFF01_0000_0000, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h1234_5678_9ABC, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'hC8C8_6464_3232, 1'b0, '0},
    '{ROW_CFG,  REG_SPREAD, 8'd1,   48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_CAP,    8'd1,   48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h1020_3040_5060, 1'b0, '0},
    '{ROW_CFG,  REG_SPREAD, 8'd24,  48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_CAP,    8'd7,   48'h0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE,   8'd8,   48'h0, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h00FF_00FF_00FF, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h0101_0101_0101, 1'b0, '0},
    '{ROW_ITEM, REG_SPREAD, 8'h00, 48'h8000_0000_0080, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_data = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [SPREAD_W-1:0] spread_r = SPREAD_RST;
  cnt_t                cap_r = CAP_RST;
  cnt_t                base_r = BASE_RST;

  out_beat_t score_q [$];
  out_beat_t seen_want;
  int        bad_cnt = 0;
  logic      calm = 1'b0;
  int        stall_run = 0;
  logic      stall_on = 1'b0;
  logic      next_cfg;

  capped_divisor_apportion dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("tb_top failed");
    $finish;
  end

  // d'hondt with cap, cross-multiplied claims, ties to the lower index
  function automatic out_beat_t apportion(input in_beat_t beat);
    weight_t         w [LANES];
    cnt_t            held [LANES];
    score_t          s [LANES];
    logic [SPREAD_W-1:0] given;
    logic            short_f;
    int              lead;
    den_t            d_lead;
    den_t            d_cand;
    prod_t           p_cand;
    prod_t           p_lead;
    out_beat_t       res;
    w[0] = beat.weight_0[WUSE-1:0];
    w[1] = beat.weight_1[WUSE-1:0];
    w[2] = beat.weight_2[WUSE-1:0];
    w[3] = beat.weight_3[WUSE-1:0];
    w[4] = beat.weight_4[WUSE-1:0];
    w[5] = beat.weight_5[WUSE-1:0];
    for (int i = 0; i < LANES; i++) held[i] = '0;
    given = '0;
    short_f = 1'b0;
    while (given < spread_r && !short_f) begin
      lead = NO_PICK;
      for (int i = 0; i < BUCKETS && i < LANES; i++) begin
        if (held[i] < cap_r) begin
          if (lead == NO_PICK) begin
            lead = i;
          end else begin
            d_lead = den_t'(held[lead]) + den_t'(1);
            d_cand = den_t'(held[i]) + den_t'(1);
            p_cand = prod_t'(w[i]) * prod_t'(d_lead);
            p_lead = prod_t'(w[lead]) * prod_t'(d_cand);
            if (p_cand > p_lead) lead = i;
          end
        end
      end
      if (lead == NO_PICK) begin
        short_f = 1'b1;
      end else begin
        held[lead] = held[lead] + cnt_t'(1);
        given = given + SPREAD_W'(1);
      end
    end
    for (int i = 0; i < LANES; i++) begin
      s[i] = '0;
      if (i < BUCKETS) s[i] = score_t'(base_r) + score_t'(held[i]);
    end
    res.score_0 = s[0];
    res.score_1 = s[1];
    res.score_2 = s[2];
    res.score_3 = s[3];
    res.score_4 = s[4];
    res.score_5 = s[5];
    res.short_total = short_f;
    return res;
  endfunction

  function automatic int span_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int in_gap();
    if (calm) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return span_len();
  endfunction

  function automatic in_beat_t rand_beat();
    logic [FIELD_W-1:0] w [LANES];
    int                 mode;
    in_beat_t           b;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < LANES; i++) begin
      case (mode)
        0: w[i] = (i == 0) ? FIELD_W'($urandom_range(0, 255)) : w[0];
        1: w[i] = FIELD_W'($urandom_range(0, 3));
        2: w[i] = ($urandom_range(0, 1) == 1) ? '1 : '0;
        default: w[i] = FIELD_W'($urandom_range(0, 255));
      endcase
    end
    b.weight_0 = w[0];
    b.weight_1 = w[1];
    b.weight_2 = w[2];
    b.weight_3 = w[3];
    b.weight_4 = w[4];
    b.weight_5 = w[5];
    return b;
  endfunction

  task automatic send_item(input in_beat_t beat, input logic typed, input out_beat_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    if (typed) score_q.push_back(want);
    else score_q.push_back(apportion(beat));
    gap = in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      REG_SPREAD: spread_r = val;
      REG_CAP:    cap_r = val[CNT_W-1:0];
      REG_BASE:   base_r = val[CNT_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_on = ($urandom_range(0, 99) < 40);
        stall_run = span_len();
      end
      stall_run = stall_run - 1;
      out_stall <= stall_on;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (score_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        seen_want = score_q.pop_front();
        if (out_data_o.score_0 !== seen_want.score_0 ||
            out_data_o.score_1 !== seen_want.score_1 ||
            out_data_o.score_2 !== seen_want.score_2 ||
            out_data_o.score_3 !== seen_want.score_3 ||
            out_data_o.score_4 !== seen_want.score_4 ||
            out_data_o.score_5 !== seen_want.score_5 ||
            out_data_o.short_total !== seen_want.short_total) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("result mismatch exp %p got %p", seen_want, out_data_o);
        end
      end
    end
  end

  initial begin : stim
    int sp;
    int cp;
    int bs;
    int n_items;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        if (r == 0 || DIR_TAB[r-1].kind != ROW_CFG) drain();
        next_cfg = (r + 1 < DIR_N) ? (DIR_TAB[r+1].kind == ROW_CFG) : 1'b0;
        write_reg(DIR_TAB[r].idx, DIR_TAB[r].data, !next_cfg);
      end else begin
        send_item(DIR_TAB[r].beat, DIR_TAB[r].typed, DIR_TAB[r].want);
      end
    end

    for (int p = 0; p < 12; p++) begin
      drain();
      calm <= (p == 5 || p == 9);
      case (p)
        0: begin sp = 24;  cp = 7;  bs = 8;  end
        1: begin sp = 255; cp = 31; bs = 31; end
        2: begin sp = 0;   cp = 30; bs = 0;  end
        3: begin sp = 180; cp = 30; bs = 30; end
        4: begin sp = 6;   cp = 0;  bs = 31; end
        default: begin
          sp = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 255) : $urandom_range(0, 40);
          cp = $urandom_range(0, 31);
          bs = $urandom_range(0, 31);
        end
      endcase
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 255)), 1'b0);
      write_reg(REG_SPREAD, CFG_DATA_W'(sp), 1'b0);
      write_reg(REG_CAP, CFG_DATA_W'(($urandom_range(0, 7) << CNT_W) | cp), 1'b0);
      write_reg(REG_BASE, CFG_DATA_W'(($urandom_range(0, 7) << CNT_W) | bs), 1'b1);
      n_items = (p == 1 || p == 3) ? 40 : 110;
      for (int k = 0; k < n_items; k++) begin
        // occasionally let every result come home before the next beat
        if ($urandom_range(0, 49) == 0) drain();
        send_item(rand_beat(), 1'b0, '0);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (bad_cnt == 0 && score_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
